### hw/rtl/bcfp_pkg.sv
// Shared constants, types and helpers for the boot command frame parser.
// Depends on nothing; imported by the parser and its output stage.
`default_nettype none

package bcfp_pkg;

    localparam int SUBPAGE_BYTES   = 32;
    localparam int MAX_FRAME_BYTES = 75;

    localparam int ADDR_W = $clog2(MAX_FRAME_BYTES);
    localparam int CNT_W  = $clog2(MAX_FRAME_BYTES + 1);
    localparam int KCNT_W = (SUBPAGE_BYTES > 1) ? $clog2(SUBPAGE_BYTES) : 1;

    // Frame lengths count the leading '*' and the newline
    localparam int SHORT_LEN   = 7;
    localparam int VERIFY_LEN  = 15;
    localparam int PROGRAM_LEN = 11 + 2 * SUBPAGE_BYTES;
    localparam bit PROG_FITS   = (PROGRAM_LEN <= MAX_FRAME_BYTES);

    localparam int PARAM_POS   = 6;
    localparam int PARAM_END   = 14;
    localparam int PAYLOAD_POS = 10;

    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;

    localparam logic [39:0] WORD_PING  = "+P1NG";
    localparam logic [39:0] WORD_CLEAR = "CLEAR";
    localparam logic [39:0] WORD_PROGR = "PROGR";
    localparam logic [39:0] WORD_VERIF = "VERIF";

    localparam logic [2:0] CMD_REJECT  = 3'd0;
    localparam logic [2:0] CMD_PING    = 3'd1;
    localparam logic [2:0] CMD_ERASE   = 3'd2;
    localparam logic [2:0] CMD_PROGRAM = 3'd3;
    localparam logic [2:0] CMD_VERIFY  = 3'd4;
    localparam logic [2:0] CMD_PAGE_OOR = 3'd5;

    localparam logic KIND_HEADER  = 1'b0;
    localparam logic KIND_PAYLOAD = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [2:0]  code;
        logic [31:0] param;
        logic [7:0]  data;
        logic        last;
    } res_t;

    function automatic logic hex_ok(input logic [7:0] c);
        return ((c >= 8'h30) && (c <= 8'h39)) || ((c >= 8'h41) && (c <= 8'h46));
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [7:0] v;
        v = (c <= 8'h39) ? (c - 8'h30) : (c - 8'h37);
        return v[3:0];
    endfunction

    // Character i (0 = leftmost) of a five-character command word
    function automatic logic [7:0] word_char(input logic [39:0] w, input logic [2:0] i);
        logic [7:0] ch;
        case (i)
            3'd0:    ch = w[39:32];
            3'd1:    ch = w[31:24];
            3'd2:    ch = w[23:16];
            3'd3:    ch = w[15:8];
            3'd4:    ch = w[7:0];
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/bcfp_ram.sv
// Generic single-port-write, single-port-read synchronous RAM with registered read data.
// Read data holds its value while no read is issued. No dependencies.
`default_nettype none

module bcfp_ram #(
    parameter int DEPTH = 75,
    parameter int WIDTH = 8,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

### hw/rtl/bcfp_out_stage.sv
// Output register of the parser: holds one result item until it is taken.
// Depends on bcfp_pkg for the result type.
`default_nettype none

module bcfp_out_stage
    import bcfp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    input  wire res_t        push_item,
    output logic             can_push,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             item_kind,
    output logic [2:0]       command_code,
    output logic [31:0]      param_value,
    output logic [7:0]       data_byte,
    output logic             last
);

    logic valid_reg;
    res_t item_reg;

    assign can_push = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (push)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            item_reg <= push_item;
        end
    end

    assign out_valid    = valid_reg;
    assign item_kind    = item_reg.kind;
    assign command_code = item_reg.code;
    assign param_value  = item_reg.param;
    assign data_byte    = item_reg.data;
    assign last         = item_reg.last;

endmodule

`default_nettype wire

### hw/rtl/boot_command_frame_parser.sv
// Boot command frame parser. While receiving, the block takes one byte per cycle
// (in_ready is high) and writes each frame byte into a 75-entry frame RAM. When the
// newline arrives, ready drops: a frame of a legal length (7, 15 or the program
// length) is scanned back from the RAM at one byte per cycle, and ready stays low
// until the header item has been issued, which waits on any output stall.
// An accepted program frame then drains its payload, each byte taking two RAM reads
// (high and low digit) and one output slot, which waits on any output stall.
// Frames of any other length skip the scan and go straight to a rejected header.
// No clearing pass follows reset.
// Depends on bcfp_pkg, bcfp_ram and bcfp_out_stage.
`default_nettype none

module boot_command_frame_parser
    import bcfp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [15:0] cfg_wr_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  rx_byte,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             item_kind,
    output logic [2:0]       command_code,
    output logic [31:0]      param_value,
    output logic [7:0]       data_byte,
    output logic             last
);

    localparam logic [2:0] S_RECV    = 3'd0;
    localparam logic [2:0] S_SCAN    = 3'd1;
    localparam logic [2:0] S_HDR     = 3'd2;
    localparam logic [2:0] S_PAY_HI  = 3'd3;
    localparam logic [2:0] S_PAY_LO  = 3'd4;
    localparam logic [2:0] S_PAY_OUT = 3'd5;

    localparam logic [CNT_W-1:0] LEN_SHORT  = CNT_W'(SHORT_LEN);
    localparam logic [CNT_W-1:0] LEN_VERIFY = CNT_W'(VERIFY_LEN);
    localparam logic [CNT_W-1:0] LEN_PROG   = CNT_W'(PROG_FITS ? PROGRAM_LEN : SHORT_LEN);
    localparam logic [CNT_W-1:0] LEN_MAX    = CNT_W'(MAX_FRAME_BYTES);
    localparam logic [CNT_W-1:0] POS_PARAM  = CNT_W'(PARAM_POS);
    localparam logic [CNT_W-1:0] POS_PEND   = CNT_W'(PARAM_END);
    localparam logic [CNT_W-1:0] POS_PAY    = CNT_W'(PAYLOAD_POS);
    localparam logic [KCNT_W-1:0] K_LAST    = KCNT_W'(SUBPAGE_BYTES - 1);

    logic [2:0]        state_reg, state_next;
    logic [CNT_W-1:0]  fill_reg, fill_next;
    logic [CNT_W-1:0]  len_reg, len_next;
    logic [CNT_W-1:0]  last_pos_reg, last_pos_next;
    logic [CNT_W-1:0]  rd_addr_reg, rd_addr_next;
    logic [CNT_W-1:0]  chk_reg, chk_next;
    logic              rdv_reg, rdv_next;
    logic [3:0]        match_reg, match_next;   // ping, clear, progr, verif
    logic              hex_reg, hex_next;
    logic [31:0]       param_reg, param_next;
    logic [3:0]        hi_reg, hi_next;
    logic [KCNT_W-1:0] k_reg, k_next;
    logic [15:0]       max_page_reg;

    logic              ram_we, ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [7:0]        ram_rdata;
    logic              push, can_push;
    res_t              push_item;

    logic              in_acc;
    logic [CNT_W-1:0]  n_len;
    logic [2:0]        cidx;
    logic [CNT_W-1:0]  cpos_m1;
    logic [15:0]       sub;
    logic              is_ping, is_clear, is_verify, is_prog;

    assign in_acc   = in_valid && in_ready;
    assign in_ready = (state_reg == S_RECV);
    assign n_len    = fill_reg + CNT_W'(1);
    assign ram_we   = in_acc && !((fill_reg == '0) && (rx_byte != CH_STAR));
    assign cpos_m1  = chk_reg - CNT_W'(1);
    assign cidx     = cpos_m1[2:0];
    assign sub      = param_reg[31:16];

    assign is_ping   = (len_reg == LEN_SHORT) && match_reg[0];
    assign is_clear  = (len_reg == LEN_SHORT) && match_reg[1];
    assign is_prog   = PROG_FITS && (len_reg == LEN_PROG) && match_reg[2] && hex_reg;
    assign is_verify = (len_reg == LEN_VERIFY) && match_reg[3] && hex_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_page_reg <= 16'd63;
        end
        else if (cfg_wr_en)
        begin
            max_page_reg <= cfg_wr_data;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        fill_next     = fill_reg;
        len_next      = len_reg;
        last_pos_next = last_pos_reg;
        rd_addr_next  = rd_addr_reg;
        chk_next      = chk_reg;
        rdv_next      = 1'b0;
        match_next    = match_reg;
        hex_next      = hex_reg;
        param_next    = param_reg;
        hi_next       = hi_reg;
        k_next        = k_reg;
        ram_re        = 1'b0;
        ram_raddr     = rd_addr_reg[ADDR_W-1:0];
        push          = 1'b0;
        push_item     = '{kind: KIND_HEADER, code: CMD_REJECT, param: 32'd0,
                          data: 8'd0, last: 1'b1};

        unique case (state_reg)
            S_RECV:
            begin
                if (ram_we)
                begin
                    if (rx_byte == CH_NEWLINE)
                    begin
                        fill_next     = '0;
                        len_next      = n_len;
                        last_pos_next = n_len - CNT_W'(2);
                        rd_addr_next  = CNT_W'(1);
                        match_next    = 4'b1111;
                        hex_next      = 1'b1;
                        param_next    = 32'd0;
                        if ((n_len == LEN_SHORT) || (n_len == LEN_VERIFY) ||
                            (PROG_FITS && (n_len == LEN_PROG)))
                        begin
                            state_next = S_SCAN;
                        end
                        else
                        begin
                            // length alone rejects the frame
                            match_next = 4'b0000;
                            state_next = S_HDR;
                        end
                    end
                    else
                    begin
                        fill_next = (n_len >= LEN_MAX) ? '0 : n_len;
                    end
                end
            end

            S_SCAN:
            begin
                if (rd_addr_reg <= last_pos_reg)
                begin
                    ram_re       = 1'b1;
                    rdv_next     = 1'b1;
                    chk_next     = rd_addr_reg;
                    rd_addr_next = rd_addr_reg + CNT_W'(1);
                end
                if (rdv_reg)
                begin
                    if (chk_reg < POS_PARAM)
                    begin
                        match_next[0] = match_reg[0] && (ram_rdata == word_char(WORD_PING, cidx));
                        match_next[1] = match_reg[1] && (ram_rdata == word_char(WORD_CLEAR, cidx));
                        match_next[2] = match_reg[2] && (ram_rdata == word_char(WORD_PROGR, cidx));
                        match_next[3] = match_reg[3] && (ram_rdata == word_char(WORD_VERIF, cidx));
                    end
                    else
                    begin
                        hex_next = hex_reg && hex_ok(ram_rdata);
                        if (chk_reg < POS_PEND)
                        begin
                            param_next = {param_reg[27:0], hex_val(ram_rdata)};
                        end
                    end
                    if (chk_reg == last_pos_reg)
                    begin
                        state_next = S_HDR;
                    end
                end
            end

            S_HDR:
            begin
                if (can_push)
                begin
                    push       = 1'b1;
                    state_next = S_RECV;
                    if (is_ping)
                    begin
                        push_item.code = CMD_PING;
                    end
                    else if (is_clear)
                    begin
                        push_item.code = CMD_ERASE;
                    end
                    else if (is_verify)
                    begin
                        push_item.code  = CMD_VERIFY;
                        push_item.param = param_reg;
                    end
                    else if (is_prog)
                    begin
                        push_item.param = {16'd0, sub};
                        if (sub > max_page_reg)
                        begin
                            push_item.code = CMD_PAGE_OOR;
                        end
                        else
                        begin
                            push_item.code = CMD_PROGRAM;
                            push_item.last = 1'b0;
                            rd_addr_next   = POS_PAY;
                            k_next         = '0;
                            state_next     = S_PAY_HI;
                        end
                    end
                end
            end

            S_PAY_HI:
            begin
                ram_re       = 1'b1;
                rd_addr_next = rd_addr_reg + CNT_W'(1);
                state_next   = S_PAY_LO;
            end

            S_PAY_LO:
            begin
                hi_next      = hex_val(ram_rdata);
                ram_re       = 1'b1;
                rd_addr_next = rd_addr_reg + CNT_W'(1);
                state_next   = S_PAY_OUT;
            end

            S_PAY_OUT:
            begin
                // read data holds here until the output slot frees
                if (can_push)
                begin
                    push      = 1'b1;
                    push_item = '{kind: KIND_PAYLOAD, code: CMD_PROGRAM,
                                  param: {16'd0, sub},
                                  data: {hi_reg, hex_val(ram_rdata)},
                                  last: (k_reg == K_LAST)};
                    if (k_reg == K_LAST)
                    begin
                        state_next = S_RECV;
                    end
                    else
                    begin
                        k_next     = k_reg + KCNT_W'(1);
                        state_next = S_PAY_HI;
                    end
                end
            end

            default:
            begin
                state_next = S_RECV;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_RECV;
            fill_reg  <= '0;
            rdv_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            rdv_reg   <= rdv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg      <= len_next;
        last_pos_reg <= last_pos_next;
        rd_addr_reg  <= rd_addr_next;
        chk_reg      <= chk_next;
        match_reg    <= match_next;
        hex_reg      <= hex_next;
        param_reg    <= param_next;
        hi_reg       <= hi_next;
        k_reg        <= k_next;
    end

    // Writes happen only while receiving and reads only while ready is low,
    // so a read never overlaps a write to the same entry.
    bcfp_ram #(
        .DEPTH (MAX_FRAME_BYTES),
        .WIDTH (8)
    ) u_frame_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (fill_reg[ADDR_W-1:0]),
        .wdata (rx_byte),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    bcfp_out_stage u_out_stage (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .push_item    (push_item),
        .can_push     (can_push),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .item_kind    (item_kind),
        .command_code (command_code),
        .param_value  (param_value),
        .data_byte    (data_byte),
        .last         (last)
    );

endmodule

`default_nettype wire

### sim/bcfp_frame_checker.sv
`timescale 1ns / 100ps
// Result checker for the boot command frame parser: mirrors the frame buffer from the
// accepted bytes, predicts the result items of every frame and compares them in order.
// Depends on bcfp_pkg.
module bcfp_frame_checker
    import bcfp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [7:0]  rx_byte,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic        item_kind,
    input  logic [2:0]  command_code,
    input  logic [31:0] param_value,
    input  logic [7:0]  data_byte,
    input  logic        last,
    output int          mismatch_count,
    output int          results_owed
);

    logic [7:0]  frame_mem [MAX_FRAME_BYTES];
    int          frame_fill;
    logic [15:0] page_limit;
    res_t        expected_results [$];
    int          clr;

    // {bad, nibble}: bad is set for anything outside 0-9 and A-F
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        if (c >= "0" && c <= "9")
            return {1'b0, c[3:0]};
        if (c >= "A" && c <= "F")
            return {1'b0, c[3:0] + 4'd9};
        return 5'h10;
    endfunction

    // Value of count hex digits starting at from; bit 32 flags a non-hex digit
    function automatic logic [32:0] hex_field(input int from, input int count);
        logic [32:0] acc;
        logic [4:0]  d;
        int          i;
        acc = '0;
        for (i = 0; i < count; i++)
        begin
            d   = hex_digit(frame_mem[from + i]);
            acc = {acc[32] | d[4], acc[27:0], d[3:0]};
        end
        return acc;
    endfunction

    task automatic decode_frame(input int n);
        logic [39:0] word;
        logic [32:0] field;
        logic [32:0] all_digits;
        res_t        r;
        int          k;
        word = {frame_mem[1], frame_mem[2], frame_mem[3], frame_mem[4], frame_mem[5]};
        r      = '0;
        r.kind = KIND_HEADER;
        r.code = CMD_REJECT;
        r.last = 1'b1;
        if (n == SHORT_LEN && word == WORD_PING)
            r.code = CMD_PING;
        else if (n == SHORT_LEN && word == WORD_CLEAR)
            r.code = CMD_ERASE;
        else if (n == VERIFY_LEN && word == WORD_VERIF)
        begin
            field = hex_field(PARAM_POS, 8);
            if (!field[32])
            begin
                r.code  = CMD_VERIFY;
                r.param = field[31:0];
            end
        end
        else if (n == PROGRAM_LEN && word == WORD_PROGR)
        begin
            all_digits = hex_field(PARAM_POS, n - 7);
            if (!all_digits[32])
            begin
                field   = hex_field(PARAM_POS, 4);
                r.param = {16'h0000, field[15:0]};
                if (field[15:0] > page_limit)
                    r.code = CMD_PAGE_OOR;
                else
                begin
                    r.code = CMD_PROGRAM;
                    r.last = 1'b0;
                end
            end
        end
        expected_results.push_back(r);
        if (r.code == CMD_PROGRAM)
        begin
            r.kind = KIND_PAYLOAD;
            for (k = 0; k < SUBPAGE_BYTES; k++)
            begin
                field  = hex_field(PAYLOAD_POS + 2 * k, 2);
                r.data = field[7:0];
                r.last = (k == SUBPAGE_BYTES - 1);
                expected_results.push_back(r);
            end
        end
    endtask

    task automatic take_byte(input logic [7:0] b);
        // outside a frame only a star counts
        if (frame_fill != 0 || b == CH_STAR)
        begin
            frame_mem[frame_fill] = b;
            frame_fill++;
            if (b == CH_NEWLINE)
            begin
                decode_frame(frame_fill);
                frame_fill = 0;
            end
            else if (frame_fill >= MAX_FRAME_BYTES)
                frame_fill = 0;     // drop the overlong frame
        end
    endtask

    task automatic report(input string what, input res_t want, input res_t got);
        mismatch_count++;
        if (mismatch_count <= 10)
        begin
            $display("%0t %s: expected kind %0d code %0d param %h data %h last %0d",
                     $time, what, want.kind, want.code, want.param, want.data, want.last);
            $display("%0t %s: actual   kind %0d code %0d param %h data %h last %0d",
                     $time, what, got.kind, got.code, got.param, got.data, got.last);
        end
    endtask

    task automatic check_result();
        res_t got;
        res_t want;
        got.kind  = item_kind;
        got.code  = command_code;
        got.param = param_value;
        got.data  = data_byte;
        got.last  = last;
        if (expected_results.size() == 0)
            report("unexpected result item", '0, got);
        else
        begin
            want = expected_results.pop_front();
            if (got.kind !== want.kind || got.code !== want.code
                || got.param !== want.param || got.data !== want.data
                || got.last !== want.last)
                report("result item mismatch", want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_fill = 0;
            page_limit = 16'd63;
            expected_results.delete();
            for (clr = 0; clr < MAX_FRAME_BYTES; clr++)
                frame_mem[clr] = 8'h00;
            mismatch_count = 0;
            results_owed   = 0;
        end
        else
        begin
            if (cfg_wr_en)
                page_limit = cfg_wr_data;
            if (in_valid && in_ready)
                take_byte(rx_byte);
            if (out_valid && out_ready)
                check_result();
            results_owed = expected_results.size();
        end
    end

endmodule

### sim/boot_command_frame_parser_test.sv
`timescale 1ns / 100ps
// Top of the boot command frame parser testbench: clock, reset, byte and page-limit
// stimulus, output flow control and the verdict.
// Depends on bcfp_pkg, the parser RTL and bcfp_frame_checker.
module boot_command_frame_parser_test;
    import bcfp_pkg::*;

    typedef enum int { FR_PING, FR_ERASE, FR_VERIFY, FR_PROGRAM } frame_kind_e;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [15:0] cfg_wr_data;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  rx_byte;
    logic        out_valid;
    logic        out_ready;
    logic        item_kind;
    logic [2:0]  command_code;
    logic [31:0] param_value;
    logic [7:0]  data_byte;
    logic        last;
    int          mismatch_count;
    int          results_owed;

    logic        quiet = 1'b0;      // no idling on either side while set
    int          out_hold_len;      // long receiver hold requested by the stimulus
    logic [7:0]  frame_q [$];

    always #4 clk = ~clk;

    boot_command_frame_parser uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .item_kind    (item_kind),
        .command_code (command_code),
        .param_value  (param_value),
        .data_byte    (data_byte),
        .last         (last)
    );

    bcfp_frame_checker frame_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .rx_byte        (rx_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .item_kind      (item_kind),
        .command_code   (command_code),
        .param_value    (param_value),
        .data_byte      (data_byte),
        .last           (last),
        .mismatch_count (mismatch_count),
        .results_owed   (results_owed)
    );

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = 0;
        if (!quiet && $urandom_range(0, 7) == 0)
            gap = $urandom_range(1, 13);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_frame();
        int i;
        for (i = 0; i < frame_q.size(); i++)
            send_byte(frame_q[i]);
        frame_q.delete();
    endtask

    // Wait for every owed result, then let the parser go quiet
    task automatic settle();
        in_valid <= 1'b0;
        while (results_owed != 0)
            @(negedge clk);
        repeat (100) @(negedge clk);
    endtask

    task automatic write_page_limit(input logic [15:0] v);
        settle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(negedge clk);
        cfg_wr_en  <= 1'b0;
    endtask

    task automatic add_word(input logic [39:0] w);
        int i;
        for (i = 4; i >= 0; i--)
            frame_q.push_back(w[i * 8 +: 8]);
    endtask

    task automatic add_hex(input logic [31:0] v, input int digits);
        int         i;
        logic [3:0] nib;
        for (i = digits - 1; i >= 0; i--)
        begin
            nib = v[i * 4 +: 4];
            frame_q.push_back((nib < 4'd10) ? 8'h30 + {4'd0, nib} : 8'h37 + {4'd0, nib});
        end
    endtask

    // fill: 0 random payload, 1 all 00, otherwise all FF
    task automatic build_frame(input frame_kind_e kind, input logic [31:0] param,
                               input int fill);
        int         k;
        logic [7:0] b;
        frame_q.push_back(CH_STAR);
        case (kind)
            FR_PING:
                add_word(WORD_PING);
            FR_ERASE:
                add_word(WORD_CLEAR);
            FR_VERIFY:
            begin
                add_word(WORD_VERIF);
                add_hex(param, 8);
            end
            default:
            begin
                add_word(WORD_PROGR);
                add_hex(param, 4);
                for (k = 0; k < SUBPAGE_BYTES; k++)
                begin
                    case (fill)
                        0:       b = 8'($urandom_range(0, 255));
                        1:       b = 8'h00;
                        default: b = 8'hFF;
                    endcase
                    add_hex({24'd0, b}, 2);
                end
            end
        endcase
        frame_q.push_back(CH_NEWLINE);
    endtask

    // Damage one spot of the frame between the star and the newline, or drop the newline
    task automatic break_frame();
        int at;
        at = $urandom_range(1, frame_q.size() - 2);
        case ($urandom_range(0, 4))
            0: frame_q[at] = 8'($urandom_range(0, 255));
            1: frame_q.delete(at);
            2: frame_q.insert(at, 8'($urandom_range(0, 255)));
            3:
                case ($urandom_range(0, 5))
                    0:       frame_q[at] = "/";
                    1:       frame_q[at] = ":";
                    2:       frame_q[at] = "@";
                    3:       frame_q[at] = "G";
                    4:       frame_q[at] = "a";
                    default: frame_q[at] = "f";
                endcase
            default: frame_q.delete(frame_q.size() - 1);
        endcase
    endtask

    task automatic run_directed();
        int i;
        logic [7:0] b;
        // bytes outside a frame are ignored
        send_byte(8'h00);
        send_byte(CH_NEWLINE);
        build_frame(FR_PING, 0, 0);
        send_frame();

        // erase with one random spot damaged, then a ping to close any open frame
        build_frame(FR_ERASE, 0, 0);
        break_frame();
        send_frame();
        build_frame(FR_PING, 0, 0);
        send_frame();

        build_frame(FR_VERIFY, $urandom, 0);
        send_frame();

        // digits just outside the hex ranges
        build_frame(FR_VERIFY, 32'h1234_5678, 0);
        frame_q[PARAM_POS] = ":";
        frame_q[PARAM_POS + 7] = "@";
        send_frame();

        // empty frame and a stray star inside the command
        frame_q.push_back(CH_STAR);
        frame_q.push_back(CH_NEWLINE);
        send_frame();
        frame_q.push_back(CH_STAR);
        add_word("+P*NG");
        frame_q.push_back(CH_NEWLINE);
        send_frame();

        // overlong frame is dropped, then a non-star byte is ignored
        frame_q.push_back(CH_STAR);
        for (i = 1; i < MAX_FRAME_BYTES; i++)
        begin
            b = 8'($urandom_range(0, 255));
            frame_q.push_back((b == CH_NEWLINE) ? 8'h0B : b);
        end
        send_frame();
        send_byte("X");
    endtask

    // Receiver: random stalls, plus one long hold on request
    initial
    begin
        int hold;
        out_ready    = 1'b0;
        out_hold_len = 0;
        forever
        begin
            @(negedge clk);
            if (out_hold_len > 0)
            begin
                hold         = out_hold_len;
                out_hold_len = 0;
                out_ready <= 1'b0;
                repeat (hold) @(negedge clk);
                out_ready <= 1'b1;
            end
            else if (!quiet && rst_n && $urandom_range(0, 9) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(negedge clk);
                out_ready <= 1'b1;
            end
            else
                out_ready <= 1'b1;
        end
    end

    initial
    begin
        #(5_000_000);
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        rst_n       = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = 16'h0000;
        in_valid    = 1'b0;
        rx_byte     = 8'h00;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        run_directed();

        // hold the output while a program frame at the page limit and a ping
        // arrive, so the input backs up
        out_hold_len = 1200;
        build_frame(FR_PROGRAM, 32'h003F, 2);
        send_frame();
        build_frame(FR_PING, 0, 0);
        send_frame();

        // no idling from here on; a subpage above the smallest limit
        quiet = 1'b1;
        write_page_limit(16'h0000);
        build_frame(FR_PROGRAM, 32'h0001, 0);
        send_frame();

        settle();
        if (mismatch_count == 0 && results_owed == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
